// ----- sv/lzhd_pkg.sv -----
// Shared constants and types for the LZ halfword decompressor.
package lzhd_pkg;

  localparam int HIST_DEPTH = 2048;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int POS_W      = 32;
  localparam int CMD_BYTES_W = 31;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int HW_W       = 16;
  localparam int DIST_W     = 11;
  localparam int LEN_W      = 4;

  localparam logic [HW_W-1:0] LIT_END_MASK = 16'h0020;

  localparam logic MODE_LIT = 1'b0;
  localparam logic MODE_CMD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CMD_BYTES  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN = 8'd1;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_KIND = 2'd1,
    ERR_DIST = 2'd2,
    ERR_DONE = 2'd3
  } err_t;

endpackage

// ----- sv/lzhd_in_if.sv -----
// Input stream interface carrying literal halfwords and command pairs.
interface lzhd_in_if import lzhd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            mode;
  logic [HW_W-1:0] literal_word;
  logic [7:0]      command_high;
  logic [7:0]      command_low;

  modport source (output valid, mode, literal_word, command_high, command_low, input ready);
  modport sink   (input valid, mode, literal_word, command_high, command_low, output ready);
endinterface

// ----- sv/lzhd_out_if.sv -----
// Output stream interface carrying decoded halfwords and status.
interface lzhd_out_if import lzhd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [HW_W-1:0] halfword;
  logic            last;
  logic            next_mode;
  logic            done_res;
  logic [1:0]      error;

  modport source (output valid, halfword, last, next_mode, done_res, error, input ready);
  modport sink   (input valid, halfword, last, next_mode, done_res, error, output ready);
endinterface

// ----- sv/lzhd_cfg_if.sv -----
// Configuration write interface with register index and write data.
interface lzhd_cfg_if import lzhd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/lzhd_hist_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lzhd_hist_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/lz_halfword_decompressor_core.sv -----
// Top level of the LZ halfword decompressor: decode, copy sequencer and history.
//
// A command copies len halfwords (2 to 15; a len below 2 copies two): each is
// read from the history RAM through its registered read port in the read state,
// then written back and loaded into the output register in the write state,
// which waits for a free output, so that overlapping copies at distance one see
// the halfword just written. The input is not ready while a copy runs. A result
// register sits on the output, and a new item is taken while an earlier result
// is taken in the same cycle.
module lz_halfword_decompressor_core import lzhd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  lzhd_in_if.sink      in_ch,
  lzhd_out_if.source   out_ch,
  lzhd_cfg_if.sink     cfg_ch
);

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_WRITE} state_t;
  typedef enum logic [1:0] {PH_LIT, PH_CMD, PH_DONE} phase_t;

  state_t                 state_r, state_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [POS_W-1:0]       used_r, used_nxt;
  logic [CMD_BYTES_W-1:0] cmd_bytes_r, cmd_bytes_nxt;
  logic                   big_endian_r, big_endian_nxt;
  logic [HIST_AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic [LEN_W-1:0]       remain_r, remain_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [HW_W-1:0]        out_hw_r, out_hw_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_next_mode_r, out_next_mode_nxt;
  logic                   out_done_r, out_done_nxt;
  err_t                   out_err_r, out_err_nxt;

  logic                   ram_we;
  logic                   ram_re;
  logic [HW_W-1:0]        ram_wdata;
  logic [HW_W-1:0]        ram_rdata;

  logic                   out_free;
  logic                   in_fire;
  logic                   emit;
  logic [HW_W-1:0]        lit_w;
  logic [DIST_W-1:0]      back_dist;
  logic [LEN_W-1:0]       len;
  logic                   flag;
  logic [POS_W-1:0]       used_plus;

  assign out_free      = !out_valid_r || out_ch.ready;
  assign in_ch.ready   = (state_r == ST_IDLE) && out_free;
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;

  assign back_dist = {in_ch.command_high[2:0], in_ch.command_low};
  assign len       = in_ch.command_high[7:4];
  assign flag      = in_ch.command_high[3];
  assign used_plus = used_r + POS_W'(2);

  always_comb begin
    lit_w = in_ch.literal_word;
    if (big_endian_r) begin
      lit_w = {in_ch.literal_word[7:0], in_ch.literal_word[15:8]};
    end

    state_nxt         = state_r;
    phase_nxt         = phase_r;
    pos_nxt           = pos_r;
    used_nxt          = used_r;
    cmd_bytes_nxt     = cmd_bytes_r;
    big_endian_nxt    = big_endian_r;
    rd_addr_nxt       = rd_addr_r;
    remain_nxt        = remain_r;
    out_valid_nxt     = out_valid_r && !out_ch.ready;
    out_hw_nxt        = out_hw_r;
    out_last_nxt      = out_last_r;
    out_next_mode_nxt = out_next_mode_r;
    out_done_nxt      = out_done_r;
    out_err_nxt       = out_err_r;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    ram_wdata         = lit_w;
    emit              = 1'b0;

    if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == REG_CMD_BYTES) begin
        cmd_bytes_nxt = cfg_ch.data[CMD_BYTES_W-1:0];
      end else if (cfg_ch.index == REG_BIG_ENDIAN) begin
        big_endian_nxt = cfg_ch.data[0];
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          emit         = 1'b1;
          out_last_nxt = 1'b1;
          out_hw_nxt   = '0;
          out_err_nxt  = ERR_NONE;
          if (phase_r == PH_DONE) begin
            out_err_nxt = ERR_DONE;
          end else if ((phase_r == PH_LIT && in_ch.mode != MODE_LIT) ||
                       (phase_r == PH_CMD && in_ch.mode != MODE_CMD)) begin
            out_err_nxt = ERR_KIND;
          end else if (phase_r == PH_LIT) begin
            if ((lit_w & LIT_END_MASK) != '0) begin
              lit_w     = lit_w & ~LIT_END_MASK;
              phase_nxt = (used_r >= POS_W'(cmd_bytes_r)) ? PH_DONE : PH_CMD;
            end
            ram_wdata  = lit_w;
            ram_we     = 1'b1;
            pos_nxt    = pos_r + POS_W'(1);
            out_hw_nxt = lit_w;
          end else if (back_dist == '0 || POS_W'(back_dist) > pos_r) begin
            out_err_nxt = ERR_DIST;
          end else begin
            emit        = 1'b0;
            used_nxt    = used_plus;
            if (flag) begin
              phase_nxt = PH_LIT;
            end else begin
              phase_nxt = (used_plus >= POS_W'(cmd_bytes_r)) ? PH_DONE : PH_CMD;
            end
            rd_addr_nxt = pos_r[HIST_AW-1:0] - HIST_AW'(back_dist);
            remain_nxt  = (len < LEN_W'(2)) ? LEN_W'(1) : len - LEN_W'(1);
            state_nxt   = ST_READ;
          end
        end
      end
      ST_READ: begin
        ram_re      = 1'b1;
        rd_addr_nxt = rd_addr_r + HIST_AW'(1);
        state_nxt   = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          emit         = 1'b1;
          ram_we       = 1'b1;
          ram_wdata    = ram_rdata;
          pos_nxt      = pos_r + POS_W'(1);
          out_hw_nxt   = ram_rdata;
          out_err_nxt  = ERR_NONE;
          out_last_nxt = (remain_r == '0);
          if (remain_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            remain_nxt = remain_r - LEN_W'(1);
            state_nxt  = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt     = 1'b1;
      out_next_mode_nxt = (phase_nxt == PH_CMD);
      out_done_nxt      = (phase_nxt == PH_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_LIT;
      pos_r        <= '0;
      used_r       <= '0;
      cmd_bytes_r  <= '0;
      big_endian_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      used_r       <= used_nxt;
      cmd_bytes_r  <= cmd_bytes_nxt;
      big_endian_r <= big_endian_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    rd_addr_r       <= rd_addr_nxt;
    remain_r        <= remain_nxt;
    out_hw_r        <= out_hw_nxt;
    out_last_r      <= out_last_nxt;
    out_next_mode_r <= out_next_mode_nxt;
    out_done_r      <= out_done_nxt;
    out_err_r       <= out_err_nxt;
  end

  lzhd_hist_ram #(
    .DEPTH(HIST_DEPTH),
    .WIDTH(HW_W)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r[HIST_AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.halfword  = out_hw_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.next_mode = out_next_mode_r;
  assign out_ch.done_res  = out_done_r;
  assign out_ch.error     = out_err_r;

endmodule

// ----- dv/lz_halfword_decompressor_core_tb.sv -----
// Self-checking testbench for the LZ halfword decompressor core.
module lz_halfword_decompressor_core_tb;
  import lzhd_pkg::*;

  typedef enum logic [1:0] {
    PH_RUN,
    PH_COPY,
    PH_END
  } dec_phase_t;

  typedef struct packed {
    logic            mode;
    logic [HW_W-1:0] literal_word;
    logic [7:0]      command_high;
    logic [7:0]      command_low;
  } lz_item_t;

  typedef struct packed {
    logic [HW_W-1:0] halfword;
    logic            last;
    logic            next_mode;
    logic            done_res;
    err_t            error;
  } lz_result_t;

  logic clk;
  logic rst_n;

  lzhd_in_if  in_ch();
  lzhd_out_if out_ch();
  lzhd_cfg_if cfg_ch();

  lz_halfword_decompressor_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lz_item_t   stream_q[$];
  lz_result_t decoded_q[$];
  lz_item_t   cur_item;
  lz_result_t want;
  logic       gaps_on;
  logic       rx_stall;
  int         mismatches;

  logic [HW_W-1:0]        hist_mem [HIST_DEPTH];
  logic [HIST_AW-1:0]     hist_wr;
  logic [POS_W-1:0]       out_count;
  logic [31:0]            bytes_used;
  dec_phase_t             dec_ph;
  logic [CMD_BYTES_W-1:0] cfg_cmd_bytes;
  logic                   cfg_swap;

  dec_phase_t             gen_ph;
  logic [POS_W-1:0]       gen_pos;
  logic [31:0]            gen_used;

  function automatic dec_phase_t phase_after(input logic [31:0] used);
    return (used >= {1'b0, cfg_cmd_bytes}) ? PH_END : PH_COPY;
  endfunction

  function automatic void expect_result(input logic [HW_W-1:0] hw, input logic last,
                                        input err_t code);
    lz_result_t r;
    r.halfword  = hw;
    r.last      = last;
    r.next_mode = (dec_ph == PH_COPY);
    r.done_res  = (dec_ph == PH_END);
    r.error     = code;
    decoded_q.push_back(r);
  endfunction

  function automatic void store_word(input logic [HW_W-1:0] hw);
    hist_mem[hist_wr] = hw;
    hist_wr = hist_wr + 1'b1;
    out_count = out_count + 1;
  endfunction

  function automatic void decode_item(input lz_item_t it);
    logic [HW_W-1:0]    w;
    logic [DIST_W-1:0]  back_dist;
    logic [HIST_AW-1:0] rd;
    int                 n;
    if (dec_ph == PH_END) begin
      expect_result('0, 1'b1, ERR_DONE);
    end else if ((dec_ph == PH_RUN) != (it.mode == MODE_LIT)) begin
      expect_result('0, 1'b1, ERR_KIND);
    end else if (dec_ph == PH_RUN) begin
      w = cfg_swap ? {it.literal_word[7:0], it.literal_word[15:8]} : it.literal_word;
      if ((w & LIT_END_MASK) != 0) begin
        w = w & ~LIT_END_MASK;
        dec_ph = phase_after(bytes_used);
      end
      store_word(w);
      expect_result(w, 1'b1, ERR_NONE);
    end else begin
      back_dist = {it.command_high[2:0], it.command_low};
      if (back_dist == 0 || back_dist > out_count) begin
        expect_result('0, 1'b1, ERR_DIST);
      end else begin
        n = (it.command_high[7:4] < 2) ? 2 : it.command_high[7:4];
        bytes_used = bytes_used + 2;
        dec_ph = it.command_high[3] ? PH_RUN : phase_after(bytes_used);
        // The history index is exactly as wide as the distance, so this wraps.
        rd = hist_wr - back_dist;
        for (int k = 0; k < n; k++) begin
          w = hist_mem[rd];
          rd = rd + 1'b1;
          store_word(w);
          expect_result(w, k == n - 1, ERR_NONE);
        end
      end
    end
  endfunction

  // Queues one item and tracks where the stream will be once it is decoded.
  function automatic void queue_item(input logic mode, input logic [HW_W-1:0] lit,
                                     input logic [7:0] hi, input logic [7:0] lo);
    lz_item_t          it;
    logic [HW_W-1:0]   w;
    logic [DIST_W-1:0] back_dist;
    it.mode         = mode;
    it.literal_word = lit;
    it.command_high = hi;
    it.command_low  = lo;
    stream_q.push_back(it);
    if (gen_ph == PH_RUN && mode == MODE_LIT) begin
      gen_pos = gen_pos + 1;
      w = cfg_swap ? {lit[7:0], lit[15:8]} : lit;
      if ((w & LIT_END_MASK) != 0) gen_ph = phase_after(gen_used);
    end else if (gen_ph == PH_COPY && mode == MODE_CMD) begin
      back_dist = {hi[2:0], lo};
      if (back_dist != 0 && back_dist <= gen_pos) begin
        gen_used = gen_used + 2;
        gen_pos = gen_pos + ((hi[7:4] < 2) ? 2 : hi[7:4]);
        gen_ph = hi[3] ? PH_RUN : phase_after(gen_used);
      end
    end
  endfunction

  task automatic gen_random(input int count);
    int                r;
    int                reach;
    logic [HW_W-1:0]   w;
    logic [DIST_W-1:0] back_dist;
    logic [3:0]        len;
    logic              flag;
    repeat (count) begin
      r = $urandom_range(99);
      reach = (gen_pos > 2047) ? 2047 : gen_pos;
      len = 4'($urandom_range(15));
      flag = ($urandom_range(99) < 35);
      case (gen_ph)
        PH_RUN: begin
          if (r < 85) begin
            w = HW_W'($urandom);
            if ($urandom_range(3) == 0) w = w | LIT_END_MASK;
            else w = w & ~LIT_END_MASK;
            queue_item(MODE_LIT, cfg_swap ? {w[7:0], w[15:8]} : w, 8'($urandom),
                       8'($urandom));
          end else begin
            queue_item(MODE_CMD, HW_W'($urandom), 8'($urandom), 8'($urandom));
          end
        end
        PH_COPY: begin
          if (r < 85) begin
            if ($urandom_range(1) == 1) back_dist = DIST_W'($urandom_range(reach, 1));
            else back_dist = DIST_W'($urandom_range((reach < 8) ? reach : 8, 1));
            queue_item(MODE_CMD, HW_W'($urandom), {len, flag, back_dist[10:8]},
                       back_dist[7:0]);
          end else if (r < 93) begin
            queue_item(MODE_LIT, HW_W'($urandom), 8'($urandom), 8'($urandom));
          end else begin
            if (reach < 2047 && $urandom_range(1) == 1) begin
              back_dist = DIST_W'($urandom_range(2047, reach + 1));
            end else begin
              back_dist = '0;
            end
            queue_item(MODE_CMD, HW_W'($urandom), {len, flag, back_dist[10:8]},
                       back_dist[7:0]);
          end
        end
        default: begin
          queue_item(1'($urandom_range(1)), HW_W'($urandom), 8'($urandom), 8'($urandom));
        end
      endcase
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_CMD_BYTES) cfg_cmd_bytes = val[CMD_BYTES_W-1:0];
    else if (idx == REG_BIG_ENDIAN) cfg_swap = val[0];
  endtask

  task automatic wait_idle();
    while (stream_q.size() != 0 || in_ch.valid || decoded_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAIL lz_halfword_decompressor_core");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) decode_item(cur_item);
      if (!in_ch.valid || in_ch.ready) begin
        if (stream_q.size() != 0 && !(gaps_on && $urandom_range(99) < 17)) begin
          cur_item = stream_q.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.mode         <= cur_item.mode;
          in_ch.literal_word <= cur_item.literal_word;
          in_ch.command_high <= cur_item.command_high;
          in_ch.command_low  <= cur_item.command_low;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction: halfword %h last %b next_mode %b done %b error %0d",
                   $time, out_ch.halfword, out_ch.last, out_ch.next_mode, out_ch.done_res,
                   out_ch.error);
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.halfword !== want.halfword || out_ch.last !== want.last ||
              out_ch.next_mode !== want.next_mode || out_ch.done_res !== want.done_res ||
              out_ch.error !== want.error) begin
            mismatches++;
            $display("%0t: expected halfword %h last %b next_mode %b done %b error %0d",
                     $time, want.halfword, want.last, want.next_mode, want.done_res,
                     want.error);
            $display("%0t: actual   halfword %h last %b next_mode %b done %b error %0d",
                     $time, out_ch.halfword, out_ch.last, out_ch.next_mode, out_ch.done_res,
                     out_ch.error);
          end
        end
      end
      out_ch.ready <= !rx_stall && !(gaps_on && $urandom_range(99) < 17);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_LIT;
    in_ch.literal_word = '0;
    in_ch.command_high = '0;
    in_ch.command_low = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    gaps_on = 1'b1;
    rx_stall = 1'b0;
    mismatches = 0;
    hist_wr = '0;
    out_count = '0;
    bytes_used = '0;
    dec_ph = PH_RUN;
    cfg_cmd_bytes = '0;
    cfg_swap = 1'b0;
    gen_ph = PH_RUN;
    gen_pos = '0;
    gen_used = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(REG_CMD_BYTES, 32'd2147483646);
    write_reg(REG_BIG_ENDIAN, 32'd0);
    @(negedge clk);

    // A command before any literal, then a literal run over the extremes.
    queue_item(MODE_CMD, 16'h0000, 8'hFF, 8'hFF);
    queue_item(MODE_LIT, 16'h0000, 8'h00, 8'h00);
    queue_item(MODE_LIT, 16'hFFDF, 8'h00, 8'h00);
    queue_item(MODE_LIT, 16'h0020, 8'h00, 8'h00);
    // Wrong kind and every flavor of bad distance while a command is expected.
    queue_item(MODE_LIT, 16'hFFFF, 8'h00, 8'h00);
    queue_item(MODE_CMD, 16'h0000, 8'h50, 8'h00);
    queue_item(MODE_CMD, 16'h0000, 8'h00, 8'h04);
    queue_item(MODE_CMD, 16'h0000, 8'hF7, 8'hFF);
    // Short lengths, an overlapping copy and the longest copy.
    queue_item(MODE_CMD, 16'h0000, 8'h00, 8'h01);
    queue_item(MODE_CMD, 16'h0000, 8'h10, 8'h03);
    queue_item(MODE_CMD, 16'h0000, 8'hF0, 8'h02);
    queue_item(MODE_CMD, 16'h0000, 8'h38, 8'h05);
    queue_item(MODE_LIT, 16'h1234, 8'h00, 8'h00);
    queue_item(MODE_LIT, 16'hFFFF, 8'h00, 8'h00);
    queue_item(MODE_CMD, 16'h0000, 8'hF0, 8'd27);
    queue_item(MODE_CMD, 16'h0000, 8'h28, 8'h01);
    queue_item(MODE_LIT, 16'h0021, 8'h00, 8'h00);
    wait_idle();

    write_reg(REG_BIG_ENDIAN, 32'd1);
    @(negedge clk);
    gen_random(60);
    wait_idle();

    // No gaps on either side, and the receiver holds off so that the core backs up.
    gaps_on = 1'b0;
    write_reg(REG_CMD_BYTES, $urandom_range(32'h7FFF_FFFD, 32'h0010_0000) | 32'd1);
    @(negedge clk);
    gen_random(70);
    @(posedge clk);
    rx_stall <= 1'b1;
    repeat (400) @(posedge clk);
    rx_stall <= 1'b0;
    wait_idle();

    gaps_on = 1'b1;
    write_reg(REG_BIG_ENDIAN, 32'd0);
    @(negedge clk);
    gen_random(60);
    wait_idle();

    // With no command bytes left the stream ends at the next check.
    write_reg(REG_CMD_BYTES, 32'd0);
    @(negedge clk);
    for (int g = 0; g < 200 && gen_ph != PH_END; g++) gen_random(1);
    gen_random(8);
    wait_idle();
    repeat (40) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS lz_halfword_decompressor_core");
    end else begin
      $display("FAIL lz_halfword_decompressor_core");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/lzhd_pkg.sv
sv/lzhd_in_if.sv
sv/lzhd_out_if.sv
sv/lzhd_cfg_if.sv
sv/lzhd_hist_ram.sv
sv/lz_halfword_decompressor_core.sv
dv/lz_halfword_decompressor_core_tb.sv
